// ===== hdl/rhr_pkg.sv =====
// Shared types and constants for the resizable history ring.
`default_nettype none

package rhr_pkg;

  localparam int COUNT_W = 32;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_GET    = 2'd1,
    MODE_RESIZE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_CAP  = 2'd1,
    STAT_OVERFLOW = 2'd2
  } stat_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_PUSH_WR,
    ST_GET_DIV,
    ST_RS_DIV,
    ST_DROP_RD,
    ST_DROP_EMIT,
    ST_RS_CLR,
    ST_CP_RD,
    ST_CP_WR,
    ST_RS_END,
    ST_DONE_OK,
    ST_DONE_BAD,
    ST_DONE_OVF,
    ST_DONE_RD
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic  in_take;
    logic  cnt_clr;
    logic  cnt_inc;
    logic  clr_wr;
    logic  clr_own;
    logic  push_rd;
    logic  push_wr;
    logic  get_rd;
    logic  drop_rd;
    logic  cp_rd;
    logic  cp_wr;
    logic  rs_setup;
    logic  rs_plan;
    logic  rs_commit;
    logic  div_start;
    logic  div_sel_pc;
    logic  out_load;
    logic  out_rdata;
    stat_t out_status;
    logic  out_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mode_push;
    logic mode_get;
    logic mode_resize;
    logic count_full;
    logic get_hit;
    logic cap_bad;
    logic cap_same;
    logic drop_any;
    logic keep_zero;
    logic div_done;
    logic cnt_at_max;
    logic cnt_at_ncap;
    logic cnt_at_excess;
    logic cnt_at_keep_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/rhr_div.sv =====
// Restoring remainder unit: 32-bit dividend by a narrow divisor, one bit per cycle.
`default_nettype none

module rhr_div
  import rhr_pkg::*;
#(
  parameter int CW = 7
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [COUNT_W-1:0] dividend,
  input  wire logic [CW-1:0]      divisor,
  output logic                    done,
  output logic [CW-1:0]           rem
);

  localparam int SW = $clog2(COUNT_W);

  logic               busy;
  logic [SW-1:0]      step;
  logic [COUNT_W-1:0] quo;
  logic [CW-1:0]      dvs;
  logic [CW:0]        trial;
  logic [CW:0]        dvs_ext;

  assign trial   = {rem, quo[COUNT_W-1]};
  assign dvs_ext = {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + SW'(1);
        if (step == SW'(COUNT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[COUNT_W-2:0], 1'b0};
      if (trial >= dvs_ext) begin
        rem <= CW'(trial - dvs_ext);
      end else begin
        rem <= trial[CW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rhr_datapath.sv =====
// Datapath: slot memory (two banks), counters, index registers, output register.
`default_nettype none

module rhr_datapath
  import rhr_pkg::*;
#(
  parameter int MAX_SLOTS    = 64,
  parameter int HANDLE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic [1:0]  mode,
  input  wire logic [31:0] element,
  input  wire logic [31:0] position,
  input  wire logic [6:0]  new_capacity,
  input  wire logic        report_dropped,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      handle_out,
  output logic [1:0]       status,
  output logic             last
);

  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int HW = HANDLE_WIDTH;

  // architectural state
  logic [COUNT_W-1:0] pc;
  logic [CW-1:0]      cap;
  logic [IW-1:0]      wr_idx;
  logic               bank;

  // latched request
  logic [1:0]         mode_r;
  logic [HW-1:0]      elem_r;
  logic [COUNT_W-1:0] pos_r;
  logic [6:0]         ncap_raw;
  logic               rep_r;

  // resize bookkeeping
  logic [CW-1:0]      keep;
  logic [CW-1:0]      excess;
  logic [IW-1:0]      rd_idx;
  logic [IW-1:0]      wr2_idx;
  logic [CW-1:0]      cnt;

  // bank bit on top of a full index, so each bank spans 2**IW words
  logic [HW-1:0]      mem [2**(IW+1)];
  logic [HW-1:0]      rd_data;
  logic               mem_we;
  logic               mem_re;
  logic [IW:0]        mem_waddr;
  logic [IW:0]        mem_raddr;
  logic [HW-1:0]      mem_wdata;

  logic               div_done;
  logic [CW-1:0]      div_rem;

  logic [63:0]        elem_wide;
  logic [63:0]        rd_wide;
  logic [31:0]        ncap_wide;
  logic [CW-1:0]      ncap;
  logic [COUNT_W-1:0] cap32;
  logic [CW-1:0]      filled;
  logic [CW-1:0]      keep_c;
  logic [CW-1:0]      excess_c;
  logic [CW-1:0]      sub_c;

  function automatic logic [CW-1:0] modsub(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                           input logic [CW-1:0] m);
    logic [CW:0] s;
    if ({1'b0, a} >= {1'b0, b}) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + {1'b0, m} - {1'b0, b};
    end
    return s[CW-1:0];
  endfunction

  function automatic logic [IW-1:0] modinc(input logic [IW-1:0] a, input logic [CW-1:0] m);
    logic [CW-1:0] n;
    n = CW'(a) + CW'(1);
    return (n == m) ? '0 : n[IW-1:0];
  endfunction

  assign elem_wide = 64'(element);
  assign rd_wide   = 64'(rd_data);
  assign ncap_wide = 32'(ncap_raw);
  assign ncap      = ncap_wide[CW-1:0];
  assign cap32     = COUNT_W'(cap);
  assign filled    = (pc < cap32) ? pc[CW-1:0] : cap;
  assign keep_c    = (filled < ncap) ? filled : ncap;
  assign excess_c  = filled - keep_c;
  // with reporting, walk starts at the oldest entry; otherwise at the oldest kept one
  assign sub_c     = rep_r ? filled : keep_c;

  always_comb begin
    sts.mode_push        = (mode_r == MODE_PUSH);
    sts.mode_get         = (mode_r == MODE_GET);
    sts.mode_resize      = (mode_r == MODE_RESIZE);
    sts.count_full       = (pc == COUNT_MAX);
    sts.get_hit          = (pos_r < pc) && !((pc > cap32) && (pos_r < pc - cap32));
    sts.cap_bad          = (ncap_raw == 7'd0) || (ncap_wide > 32'(MAX_SLOTS));
    sts.cap_same         = (ncap == cap);
    sts.drop_any         = rep_r && (excess != '0);
    sts.keep_zero        = (keep == '0);
    sts.div_done         = div_done;
    sts.cnt_at_max       = (cnt == CW'(MAX_SLOTS - 1));
    sts.cnt_at_ncap      = (cnt == ncap - CW'(1));
    sts.cnt_at_excess    = (cnt == excess);
    sts.cnt_at_keep_last = (cnt == keep - CW'(1));
    sts.out_free         = !out_valid || out_ready;
  end

  rhr_div #(
    .CW(CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cmd.div_sel_pc ? pc : pos_r),
    .divisor  (cmd.div_sel_pc ? ncap : cap),
    .done     (div_done),
    .rem      (div_rem)
  );

  // memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {bank, wr_idx};
    mem_wdata = elem_r;
    if (cmd.push_wr) begin
      mem_we = 1'b1;
    end else if (cmd.clr_wr) begin
      mem_we    = 1'b1;
      mem_waddr = {cmd.clr_own ? bank : ~bank, cnt[IW-1:0]};
      mem_wdata = '0;
    end else if (cmd.cp_wr) begin
      mem_we    = 1'b1;
      mem_waddr = {~bank, wr2_idx};
      mem_wdata = rd_data;
    end
    mem_re    = cmd.push_rd || cmd.get_rd || cmd.drop_rd || cmd.cp_rd;
    mem_raddr = {bank, rd_idx};
    if (cmd.push_rd) begin
      mem_raddr = {bank, wr_idx};
    end else if (cmd.get_rd) begin
      mem_raddr = {bank, div_rem[IW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      cap       <= CW'(MAX_SLOTS);
      wr_idx    <= '0;
      bank      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.push_wr) begin
        pc     <= pc + COUNT_W'(1);
        wr_idx <= modinc(wr_idx, cap);
      end
      if (cmd.rs_plan) begin
        wr_idx <= div_rem[IW-1:0];
      end
      if (cmd.rs_commit) begin
        bank <= ~bank;
        cap  <= ncap;
      end
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + CW'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      mode_r   <= mode;
      elem_r   <= elem_wide[HW-1:0];
      pos_r    <= position;
      ncap_raw <= new_capacity;
      rep_r    <= report_dropped;
    end
    if (cmd.rs_setup) begin
      keep   <= keep_c;
      excess <= excess_c;
      rd_idx <= IW'(modsub(CW'(wr_idx), sub_c, cap));
    end
    if (cmd.drop_rd || cmd.cp_rd) begin
      rd_idx <= modinc(rd_idx, cap);
    end
    if (cmd.rs_plan) begin
      wr2_idx <= IW'(modsub(div_rem, keep, ncap));
    end
    if (cmd.cp_wr) begin
      wr2_idx <= modinc(wr2_idx, ncap);
    end
    if (cmd.out_load) begin
      handle_out <= cmd.out_rdata ? rd_wide[31:0] : 32'd0;
      status     <= cmd.out_status;
      last       <= cmd.out_last;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rhr_ctrl.sv =====
// Controller state machine for the resizable history ring.
`default_nettype none

module rhr_ctrl
  import rhr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (sts.cnt_at_max) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (sts.mode_push) begin
          state_next = sts.count_full ? ST_DONE_OVF : ST_PUSH_WR;
        end else if (sts.mode_get) begin
          state_next = sts.get_hit ? ST_GET_DIV : ST_DONE_OK;
        end else if (sts.mode_resize) begin
          if (sts.cap_bad) state_next = ST_DONE_BAD;
          else if (sts.cap_same) state_next = ST_DONE_OK;
          else state_next = ST_RS_DIV;
        end else begin
          state_next = ST_DONE_OK;
        end
      end
      ST_PUSH_WR: state_next = ST_DONE_RD;
      ST_GET_DIV: begin
        if (sts.div_done) state_next = ST_DONE_RD;
      end
      ST_RS_DIV: begin
        if (sts.div_done) state_next = sts.drop_any ? ST_DROP_RD : ST_RS_CLR;
      end
      ST_DROP_RD: state_next = ST_DROP_EMIT;
      ST_DROP_EMIT: begin
        if (sts.out_free) state_next = sts.cnt_at_excess ? ST_RS_CLR : ST_DROP_RD;
      end
      ST_RS_CLR: begin
        if (sts.cnt_at_ncap) state_next = sts.keep_zero ? ST_RS_END : ST_CP_RD;
      end
      ST_CP_RD: state_next = ST_CP_WR;
      ST_CP_WR: begin
        if (sts.cnt_at_keep_last) state_next = ST_RS_END;
        else state_next = ST_CP_RD;
      end
      ST_RS_END: state_next = sts.drop_any ? ST_IDLE : ST_DONE_OK;
      ST_DONE_OK, ST_DONE_BAD, ST_DONE_OVF, ST_DONE_RD: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.out_status = STAT_OK;
    in_ready       = 1'b0;
    unique case (state)
      ST_INIT: begin
        cmd.clr_wr  = 1'b1;
        cmd.clr_own = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.cnt_clr = sts.cnt_at_max;
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.in_take = in_valid;
      end
      ST_DECODE: begin
        if (sts.mode_push) begin
          cmd.push_rd = !sts.count_full;
        end else if (sts.mode_get) begin
          cmd.div_start = sts.get_hit;
        end else if (sts.mode_resize && !sts.cap_bad && !sts.cap_same) begin
          cmd.rs_setup   = 1'b1;
          cmd.div_start  = 1'b1;
          cmd.div_sel_pc = 1'b1;
        end
      end
      ST_PUSH_WR: cmd.push_wr = 1'b1;
      ST_GET_DIV: cmd.get_rd = sts.div_done;
      ST_RS_DIV: begin
        cmd.rs_plan    = sts.div_done;
        cmd.cnt_clr    = sts.div_done;
        cmd.div_sel_pc = 1'b1;
      end
      ST_DROP_RD: begin
        cmd.drop_rd = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      ST_DROP_EMIT: begin
        cmd.out_load  = sts.out_free;
        cmd.out_rdata = 1'b1;
        cmd.out_last  = sts.cnt_at_excess;
        cmd.cnt_clr   = sts.out_free && sts.cnt_at_excess;
      end
      ST_RS_CLR: begin
        cmd.clr_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.cnt_clr = sts.cnt_at_ncap;
      end
      ST_CP_RD: cmd.cp_rd = 1'b1;
      ST_CP_WR: begin
        cmd.cp_wr   = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      ST_RS_END: cmd.rs_commit = 1'b1;
      ST_DONE_OK: begin
        cmd.out_load = sts.out_free;
        cmd.out_last = 1'b1;
      end
      ST_DONE_BAD: begin
        cmd.out_load   = sts.out_free;
        cmd.out_status = STAT_BAD_CAP;
        cmd.out_last   = 1'b1;
      end
      ST_DONE_OVF: begin
        cmd.out_load   = sts.out_free;
        cmd.out_status = STAT_OVERFLOW;
        cmd.out_last   = 1'b1;
      end
      ST_DONE_RD: begin
        cmd.out_load  = sts.out_free;
        cmd.out_rdata = 1'b1;
        cmd.out_last  = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/resizable_history_ring_unit.sv =====
// Top level of the resizable history ring: controller plus datapath.
//
//   channel | signals                                              | handshake
//   --------+------------------------------------------------------+----------------------
//   in      | mode element position new_capacity report_dropped    | in_valid / in_ready
//   out     | handle_out status last                               | out_valid / out_ready
//
// One item at a time. Push: a read, then a write. Get: in window it waits on
// the 32-step remainder unit; outside it gives a zero beat. Resize: remainder
// of the push count by the new capacity, a pass over each slot of the new
// capacity (clearing the spare bank), a read and a write per kept entry (copy
// through the single-read memory port), a read and an emit per reported dropped handle.
// After reset a clearing pass over the MAX_SLOTS slots zeroes the live bank; in_ready
// stays low during it. The output register holds a result beat while the next
// item is taken; a stalled output only holds up states that have a beat to give.
`default_nettype none

module resizable_history_ring_unit
  import rhr_pkg::*;
#(
  parameter int MAX_SLOTS    = 64,
  parameter int HANDLE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [31:0] element,
  input  wire logic [31:0] position,
  input  wire logic [6:0]  new_capacity,
  input  wire logic        report_dropped,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      handle_out,
  output logic [1:0]       status,
  output logic             last
);

  cmd_t cmd;
  sts_t sts;

  // sequencing: decode, divider waits, drop / clear / copy walks of a resize
  rhr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage: two banks so a resize lays out into the spare bank, then swaps
  rhr_datapath #(
    .MAX_SLOTS    (MAX_SLOTS),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .mode           (mode),
    .element        (element),
    .position       (position),
    .new_capacity   (new_capacity),
    .report_dropped (report_dropped),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .handle_out     (handle_out),
    .status         (status),
    .last           (last)
  );

endmodule

`default_nettype wire

// ===== test/tb_resizable_history_ring_unit.sv =====
// Self-checking testbench for resizable_history_ring_unit: directed and random beats.
`default_nettype none

module tb_resizable_history_ring_unit
  import rhr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SLOTS    = 64;
  localparam int HANDLE_WIDTH = 32;

  // Mode three has no name in the package; the block answers it with a zero beat.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int RESET_CYCLES = 11;
  localparam int IDLE_PCT     = 32;   // chance per cycle that a side idles
  localparam int HOLD_CYCLES  = 500;  // long receiver hold-off, enough to back up the input
  localparam int TAIL_CYCLES  = 100;  // settle time after the last expected beat
  // Slowest run: ~210 items, up to 63 beats that each wait out a stall, plus the
  // reset clearing pass and one hold-off.
  localparam int LIMIT_CYCLES = 600000;

  // One expected output beat.
  typedef struct packed {
    logic [31:0] handle;
    stat_t       status;
    logic        last;
  } beat_t;

  // Shadow copy of the ring. note_item advances it per accepted input beat and
  // queues the output beats that beat must produce; check_beat pops them in order.
  class ring_scoreboard;
    logic [31:0] ring [MAX_SLOTS];
    logic [31:0] count;
    logic [31:0] cap;
    beat_t       due_q[$];
    int          errors;

    function new();
      foreach (ring[i]) ring[i] = '0;
      count  = '0;
      cap    = MAX_SLOTS;
      errors = 0;
    endfunction

    function void queue_beat(logic [31:0] h, stat_t st, logic lst);
      beat_t b;
      b.handle = h;
      b.status = st;
      b.last   = lst;
      due_q.push_back(b);
    endfunction

    function void note_item(logic [1:0] md, logic [31:0] el, logic [31:0] pos,
                            logic [6:0] ncap_in, logic rep);
      logic [31:0] fresh [MAX_SLOTS];
      logic [31:0] ncap, filled, keep, excess, first, p, h;
      int unsigned i;
      ncap = {25'd0, ncap_in};
      case (md)
        MODE_PUSH: begin
          // saturated count: refused, nothing written
          if (count == COUNT_MAX) begin
            queue_beat('0, STAT_OVERFLOW, 1'b1);
          end else begin
            queue_beat(ring[count % cap], STAT_OK, 1'b1);
            ring[count % cap] = el;
            count++;
          end
        end
        MODE_GET: begin
          h = '0;
          // inside the window of the last cap pushes only
          if (pos < count && !(count > cap && pos < count - cap)) h = ring[pos % cap];
          queue_beat(h, STAT_OK, 1'b1);
        end
        MODE_RESIZE: begin
          if (ncap == 0 || ncap > MAX_SLOTS) begin
            queue_beat('0, STAT_BAD_CAP, 1'b1);
          end else if (ncap == cap) begin
            queue_beat('0, STAT_OK, 1'b1);
          end else begin
            filled = (count < cap) ? count : cap;
            keep   = (filled < ncap) ? filled : ncap;
            excess = filled - keep;
            first  = count - filled;
            // dropped handles go out oldest first, zeros included
            if (rep) begin
              for (i = 0; i < excess; i++) begin
                queue_beat(ring[(first + i) % cap], STAT_OK, i == excess - 1);
              end
            end
            foreach (fresh[j]) fresh[j] = '0;
            for (i = 0; i < keep; i++) begin
              p = count - keep + i;
              fresh[p % ncap] = ring[p % cap];
            end
            ring = fresh;
            cap  = ncap;
            if (!rep || excess == 0) queue_beat('0, STAT_OK, 1'b1);
          end
        end
        default: queue_beat('0, STAT_OK, 1'b1);
      endcase
    endfunction

    task report_mismatch(string msg);
      if (errors < 100) $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_beat(logic [31:0] h, logic [1:0] st, logic lst);
      beat_t b;
      if (due_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat handle=%h status=%0d last=%b", h, st, lst));
      end else begin
        b = due_q.pop_front();
        if (h !== b.handle)
          report_mismatch($sformatf("handle_out %h, want %h", h, b.handle));
        if (st !== b.status)
          report_mismatch($sformatf("status %0d, want %0d", st, b.status));
        if (lst !== b.last)
          report_mismatch($sformatf("last %b, want %b", lst, b.last));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  mode;
  logic [31:0] element;
  logic [31:0] position;
  logic [6:0]  new_capacity;
  logic        report_dropped;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] handle_out;
  logic [1:0]  status;
  logic        last;

  ring_scoreboard sb;
  bit calm;     // no idling on either side while set
  bit hold_go;  // asks the receiver for one long hold-off
  int cycle_count;

  resizable_history_ring_unit #(
    .MAX_SLOTS   (MAX_SLOTS),
    .HANDLE_WIDTH(HANDLE_WIDTH)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .element       (element),
    .position      (position),
    .new_capacity  (new_capacity),
    .report_dropped(report_dropped),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .handle_out    (handle_out),
    .status        (status),
    .last          (last)
  );

  always #6 clk = ~clk;

  // Mostly random payloads, with zero and all-ones handles showing up often.
  function automatic logic [31:0] rand_handle();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one beat at a falling edge, after an optional random gap, and hold it
  // until the block takes it. valid stays high on return so back-to-back beats
  // never drop it.
  task automatic send_item(logic [1:0] md, logic [31:0] el, logic [31:0] pos,
                           logic [6:0] ncap, logic rep);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    mode           = md;
    element        = el;
    position       = pos;
    new_capacity   = ncap;
    report_dropped = rep;
    in_valid       = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(md, el, pos, ncap, rep);
  endtask

  // Sender pause: nothing offered until every expected beat has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.due_q.size() != 0) @(negedge clk);
  endtask

  // One random beat, biased toward positions and sizes that hit live data.
  // Unused fields carry noise so every input bit toggles.
  task automatic rand_item();
    int unsigned pick;
    logic [1:0]  md;
    logic [31:0] el;
    logic [31:0] pos;
    logic [6:0]  ncap;
    logic        rep;
    pick = $urandom_range(0, 99);
    el   = rand_handle();
    pos  = $urandom;
    ncap = 7'($urandom);
    rep  = 1'($urandom);
    if (pick < 45) begin
      md = MODE_PUSH;
    end else if (pick < 75) begin
      md = MODE_GET;
      case ($urandom_range(0, 5))
        0:       ;  // anywhere in the 32-bit space
        1:       pos = sb.count + $urandom_range(0, 3);
        default: pos = sb.count - $urandom_range(1, sb.cap + 2);
      endcase
    end else if (pick < 94) begin
      md = MODE_RESIZE;
      case ($urandom_range(0, 9))
        0, 1:          ncap = 7'($urandom);  // bad sizes included
        2, 3, 4, 5:    ncap = 7'($urandom_range(1, 8));
        default:       ncap = 7'($urandom_range(1, MAX_SLOTS));
      endcase
    end else begin
      md = MODE_UNUSED;
    end
    send_item(md, el, pos, ncap, rep);
  endtask

  task automatic rand_burst(int n);
    repeat (n) rand_item();
  endtask

  // Fill the ring at full size, then shrink it with reporting on.
  task automatic fill_and_shrink(int pushes, logic [6:0] target, bit with_hold);
    send_item(MODE_RESIZE, $urandom, $urandom, 7'(MAX_SLOTS), 1'b0);
    repeat (pushes) send_item(MODE_PUSH, rand_handle(), $urandom, 7'($urandom), 1'($urandom));
    if (with_hold) hold_go = 1'b1;
    send_item(MODE_RESIZE, $urandom, $urandom, target, 1'b1);
  endtask

  // Receiver: random ready at falling edges; one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go   = 1'b0;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Output beats are taken at the rising edge.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_beat(handle_out, status, last);
    end
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("resizable_history_ring_unit test failed");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    mode           = MODE_PUSH;
    element        = '0;
    position       = '0;
    new_capacity   = '0;
    report_dropped = 1'b0;
    calm           = 1'b0;
    hold_go        = 1'b0;
    sb             = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty ring, extreme handles and positions, bad and same sizes,
    // shrink with and without reporting, grow, and dropped zero handles.
    send_item(MODE_GET,    '0, '0, '0, 1'b0);               // empty ring
    send_item(MODE_PUSH,   32'hFFFF_FFFF, '0, '0, 1'b0);
    send_item(MODE_PUSH,   32'h0000_0000, '0, '0, 1'b0);    // zero handle
    send_item(MODE_PUSH,   32'hA5A5_A5A5, '0, '0, 1'b0);
    send_item(MODE_PUSH,   32'h5A5A_5A5A, '0, '0, 1'b0);
    send_item(MODE_GET,    '0, 32'd0, '0, 1'b0);
    send_item(MODE_GET,    '0, 32'd3, '0, 1'b0);
    send_item(MODE_GET,    '0, 32'd4, '0, 1'b0);            // not yet pushed
    send_item(MODE_GET,    '0, 32'hFFFF_FFFF, '0, 1'b0);
    send_item(MODE_UNUSED, '1, '1, 7'd127, 1'b1);
    send_item(MODE_RESIZE, '0, '0, 7'd0, 1'b1);             // bad: zero
    send_item(MODE_RESIZE, '0, '0, 7'd65, 1'b1);            // bad: just above max
    send_item(MODE_RESIZE, '0, '0, 7'd127, 1'b0);           // bad: all ones
    send_item(MODE_RESIZE, '0, '0, 7'd64, 1'b1);            // same size
    send_item(MODE_RESIZE, '0, '0, 7'd2, 1'b1);             // shrink, two dropped
    send_item(MODE_PUSH,   32'h1234_5678, '0, '0, 1'b0);
    send_item(MODE_GET,    '0, 32'd2, '0, 1'b0);            // older than window
    send_item(MODE_GET,    '0, 32'd4, '0, 1'b0);
    send_item(MODE_RESIZE, '0, '0, 7'd1, 1'b0);             // shrink, quiet
    send_item(MODE_RESIZE, '0, '0, 7'd64, 1'b1);            // grow
    send_item(MODE_GET,    '0, 32'd4, '0, 1'b0);
    send_item(MODE_PUSH,   32'h8000_0001, '0, '0, 1'b0);
    send_item(MODE_RESIZE, '0, '0, 7'd3, 1'b1);             // drops empty slots
    wait_drained();

    // Random phases.
    rand_burst(30);
    wait_drained();
    calm = 1'b1;
    rand_burst(30);
    calm = 1'b0;
    // Largest drop while the receiver is held: the block backs up and stalls
    // its input while the sender keeps offering beats.
    fill_and_shrink(66, 7'd1, 1'b1);
    rand_burst(8);
    wait_drained();
    fill_and_shrink(30, 7'($urandom_range(1, 20)), 1'b0);
    rand_burst(20);

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.due_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.errors == 0)
      $display("resizable_history_ring_unit test passed");
    else
      $display("resizable_history_ring_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire
